>>> rtl/bthc_pkg.sv
package bthc_pkg;

  // Request codes carried on in_req_type
  localparam logic REQ_SECOND = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Set modes
  localparam logic [1:0] MODE_RUN     = 2'd0;
  localparam logic [1:0] MODE_SET_SEC = 2'd1;
  localparam logic [1:0] MODE_SET_MIN = 2'd2;
  localparam logic [1:0] MODE_SET_HR  = 2'd3;

  localparam int unsigned HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_MAX       = '1;
  localparam logic [HOLD_W-1:0] HOLD_THRESH_RST = 16'h0055;

  // Time digits, mode and hold counter
  typedef struct packed {
    logic [3:0]        sec_units;
    logic [2:0]        sec_tens;
    logic [3:0]        min_units;
    logic [2:0]        min_tens;
    logic [3:0]        hr_units;
    logic              hr_tens;
    logic [1:0]        mode;
    logic [HOLD_W-1:0] hold_cnt;
  } clk_state_t;

  // Time after reset is 01:00:00, run mode
  localparam clk_state_t STATE_RST = '{
    sec_units: 4'd0, sec_tens: 3'd0,
    min_units: 4'd0, min_tens: 3'd0,
    hr_units:  4'd1, hr_tens:  1'b0,
    mode:      MODE_RUN,
    hold_cnt:  '0
  };

  // One buffered request
  typedef struct packed {
    logic req_type;
    logic press_pending;
    logic button_held;
  } clk_req_t;

endpackage

>>> rtl/bthc_step.sv
// Next-state logic for one request: BCD carries, set-mode presses, hold counter.
module bthc_step (
  input  bthc_pkg::clk_state_t          cur,
  input  bthc_pkg::clk_req_t            req,
  input  logic [bthc_pkg::HOLD_W-1:0]   hold_threshold,
  output bthc_pkg::clk_state_t          nxt
);

  logic [3:0]               su_inc;
  logic [2:0]               st_inc;
  logic                     sec_wrap;
  logic [3:0]               mu_inc;
  logic [2:0]               mt_inc;
  logic                     min_wrap;
  logic [3:0]               hu_inc;
  logic                     ht_inc;
  logic                     bump_sec;
  logic                     bump_min;
  logic                     bump_hr;
  logic                     do_press;
  logic [bthc_pkg::HOLD_W-1:0] cnt_base;
  logic [bthc_pkg::HOLD_W-1:0] cnt_inc;

  // Seconds increment
  always_comb begin
    sec_wrap = 1'b0;
    st_inc   = cur.sec_tens;
    if (cur.sec_units >= 4'd9) begin
      su_inc = 4'd0;
      if (cur.sec_tens >= 3'd5) begin
        st_inc   = 3'd0;
        sec_wrap = 1'b1;
      end else begin
        st_inc = cur.sec_tens + 3'd1;
      end
    end else begin
      su_inc = cur.sec_units + 4'd1;
    end
  end

  // Minutes increment
  always_comb begin
    min_wrap = 1'b0;
    mt_inc   = cur.min_tens;
    if (cur.min_units >= 4'd9) begin
      mu_inc = 4'd0;
      if (cur.min_tens >= 3'd5) begin
        mt_inc   = 3'd0;
        min_wrap = 1'b1;
      end else begin
        mt_inc = cur.min_tens + 3'd1;
      end
    end else begin
      mu_inc = cur.min_units + 4'd1;
    end
  end

  // Hours increment, 12 rolls to 01
  always_comb begin
    if (cur.hr_tens && (cur.hr_units >= 4'd2)) begin
      hu_inc = 4'd1;
      ht_inc = 1'b0;
    end else if (cur.hr_units >= 4'd9) begin
      hu_inc = 4'd0;
      ht_inc = 1'b1;
    end else begin
      hu_inc = cur.hr_units + 4'd1;
      ht_inc = cur.hr_tens;
    end
  end

  // Which fields advance
  always_comb begin
    do_press = (req.req_type == bthc_pkg::REQ_SAMPLE) && req.press_pending;
    if (req.req_type == bthc_pkg::REQ_SECOND) begin
      bump_sec = (cur.mode == bthc_pkg::MODE_RUN);
      bump_min = bump_sec && sec_wrap;
      bump_hr  = bump_min && min_wrap;
    end else begin
      bump_sec = do_press && (cur.mode == bthc_pkg::MODE_SET_SEC);
      bump_min = do_press && (cur.mode == bthc_pkg::MODE_SET_MIN);
      bump_hr  = do_press && (cur.mode == bthc_pkg::MODE_SET_HR);
    end
  end

  // Press clears the hold count before the held increment
  assign cnt_base = do_press ? '0 : cur.hold_cnt;
  assign cnt_inc  = cnt_base + {{(bthc_pkg::HOLD_W-1){1'b0}}, 1'b1};

  always_comb begin
    nxt = cur;
    if (bump_sec) begin
      nxt.sec_units = su_inc;
      nxt.sec_tens  = st_inc;
    end
    if (bump_min) begin
      nxt.min_units = mu_inc;
      nxt.min_tens  = mt_inc;
    end
    if (bump_hr) begin
      nxt.hr_units = hu_inc;
      nxt.hr_tens  = ht_inc;
    end
    if (req.req_type == bthc_pkg::REQ_SAMPLE) begin
      nxt.hold_cnt = cnt_base;
      if (req.button_held && (cnt_base != bthc_pkg::HOLD_MAX)) begin
        nxt.hold_cnt = cnt_inc;
        // exact match only: a threshold at or below the count waits for a clear
        if (cnt_inc == hold_threshold) begin
          nxt.mode = cur.mode + 2'd1;
        end
      end
    end
  end

endmodule

>>> rtl/bcd_twelve_hour_clock_with_set_mode_unit.sv
// Channel | Ports                                          | Handshake
// input   | in_req_type, in_press_pending, in_button_held  | in_valid / in_stall
// result  | out_second_*, out_minute_*, out_hour_*, out_mode | out_valid / out_stall
// config  | cfg_data (hold_threshold)                      | cfg_valid / cfg_ready
//
// One transaction per cycle sustained while the result is not stalled.
// The input register holds one request; the clock state register is the result register
// and is updated as the request leaves the input register.
// Synchronous active-low reset: time 01:00:00, run mode, threshold 85, no transactions held.
// While the result is stalled, the input register still takes one more request.
module bcd_twelve_hour_clock_with_set_mode_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic                          in_press_pending,
  input  logic                          in_button_held,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_second_units,
  output logic [2:0]                    out_second_tens,
  output logic [3:0]                    out_minute_units,
  output logic [2:0]                    out_minute_tens,
  output logic [3:0]                    out_hour_units,
  output logic                          out_hour_tens,
  output logic [1:0]                    out_mode,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bthc_pkg::HOLD_W-1:0]   cfg_data
);

  logic                          in_vld_r;
  logic                          in_vld_nxt;
  bthc_pkg::clk_req_t            in_req_r;
  logic                          out_vld_r;
  logic                          out_vld_nxt;
  bthc_pkg::clk_state_t          state_r;
  bthc_pkg::clk_state_t          state_nxt;
  logic [bthc_pkg::HOLD_W-1:0]   thresh_r;
  logic                          out_load;
  logic                          advance;
  logic                          in_take;

  // Handshake control
  assign out_load   = !out_vld_r || !out_stall;
  assign advance    = in_vld_r && out_load;
  assign in_stall   = in_vld_r && !out_load;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && out_stall);
  assign cfg_ready  = 1'b1;

  // Input request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    if (in_take) begin
      in_req_r <= '{req_type: in_req_type, press_pending: in_press_pending,
                    button_held: in_button_held};
    end
  end

  bthc_step u_step (
    .cur            (state_r),
    .req            (in_req_r),
    .hold_threshold (thresh_r),
    .nxt            (state_nxt)
  );

  // Clock state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      state_r   <= bthc_pkg::STATE_RST;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= bthc_pkg::HOLD_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_data;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_second_units = state_r.sec_units;
  assign out_second_tens  = state_r.sec_tens;
  assign out_minute_units = state_r.min_units;
  assign out_minute_tens  = state_r.min_tens;
  assign out_hour_units   = state_r.hr_units;
  assign out_hour_tens    = state_r.hr_tens;
  assign out_mode         = state_r.mode;

  // A moved request always shows up as a result
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("request advanced without producing a result");

  // State only moves with a transaction
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("clock state changed with no transaction");

  // Mode never changes on a one-second tick
  a_mode_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_req_r.req_type == bthc_pkg::REQ_SECOND)) |=> $stable(state_r.mode))
    else $error("mode changed on a one-second tick");

  // Time frozen on a one-second tick in a set mode
  a_set_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_req_r.req_type == bthc_pkg::REQ_SECOND)
     && (state_r.mode != bthc_pkg::MODE_RUN)) |=> $stable(state_r))
    else $error("time advanced while in a set mode");

endmodule
